// ===== rtl/core/eow_pkg.sv =====
// ----------------------------------------------------------------------------
// eow_pkg
// Shared types, constants and helpers for the escalating outage watchdog:
// register indexes, reset values, config and result bundles.
// ----------------------------------------------------------------------------
package eow_pkg;

   // Field widths
   localparam int SEC_BITS      = 20;
   localparam int MS_SPAN_BITS  = 30;   // seconds * 1000 for a 20-bit value
   localparam int INTERVAL_BITS = 32;
   localparam int NOW_W         = 48;
   localparam int CSR_IDX_BITS  = 3;
   localparam int TIME_BITS_DEF = 48;

   localparam logic [9:0] MS_PER_S = 10'd1000;

   // Register reset values
   localparam logic [SEC_BITS-1:0] SOFT_BASE_RST   = 20'd30;
   localparam logic [SEC_BITS-1:0] SOFT_MAX_RST    = 20'd600;
   localparam logic [SEC_BITS-1:0] REBOOT_BASE_RST = 20'd300;
   localparam logic [SEC_BITS-1:0] REBOOT_MAX_RST  = 20'd3600;

   // Register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SOFT_BASE   = 3'd0,
      CSR_SOFT_MAX    = 3'd1,
      CSR_REBOOT_BASE = 3'd2,
      CSR_REBOOT_MAX  = 3'd3,
      CSR_DRY_RUN     = 3'd4
   } eow_csr_idx_type;

   typedef struct packed {
      logic [SEC_BITS-1:0] soft_base_s;
      logic [SEC_BITS-1:0] soft_max_s;
      logic [SEC_BITS-1:0] reboot_floor_sec;
      logic [SEC_BITS-1:0] reboot_cap_sec;
      logic                dry_run;
   } eow_cfg_type;

   typedef struct packed {
      logic                soft_reset;
      logic                reboot;
      logic                in_outage;
      logic [NOW_W-1:0]    down_ms;
      logic [SEC_BITS-1:0] backoff_s;
   } eow_rsp_type;

   // Convert seconds to milliseconds (constant multiply)
   function automatic logic [MS_SPAN_BITS-1:0] sec_to_ms(input logic [SEC_BITS-1:0] sec);
      return MS_SPAN_BITS'(sec) * MS_SPAN_BITS'(MS_PER_S);
   endfunction

   localparam logic [INTERVAL_BITS-1:0] SOFT_INTERVAL_RST =
      INTERVAL_BITS'(SOFT_BASE_RST) * INTERVAL_BITS'(MS_PER_S);

endpackage

// ===== rtl/core/eow_csr.sv =====
// ----------------------------------------------------------------------------
// eow_csr
// Configuration register file: five write-only registers, decoded by index.
// ----------------------------------------------------------------------------
module eow_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [eow_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [eow_pkg::SEC_BITS-1:0]      csr_wdata,
   output eow_pkg::eow_cfg_type              cfg
);
   import eow_pkg::*;

   eow_cfg_type cfg_ff;
   eow_cfg_type cfg_in;

   // Decode the write and replace the addressed field
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SOFT_BASE:   cfg_in.soft_base_s      = csr_wdata;
            CSR_SOFT_MAX:    cfg_in.soft_max_s       = csr_wdata;
            CSR_REBOOT_BASE: cfg_in.reboot_floor_sec = csr_wdata;
            CSR_REBOOT_MAX:  cfg_in.reboot_cap_sec   = csr_wdata;
            CSR_DRY_RUN:     cfg_in.dry_run          = csr_wdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.soft_base_s      <= SOFT_BASE_RST;
         cfg_ff.soft_max_s       <= SOFT_MAX_RST;
         cfg_ff.reboot_floor_sec <= REBOOT_BASE_RST;
         cfg_ff.reboot_cap_sec   <= REBOOT_MAX_RST;
         cfg_ff.dry_run          <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/eow_step.sv =====
// ----------------------------------------------------------------------------
// eow_step
// Outage state registers and the event update: deadline checks,
// interval and backoff doubling with caps, saturating deadline sums.
// ----------------------------------------------------------------------------
module eow_step #(
   parameter int TIME_BITS = eow_pkg::TIME_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  eow_pkg::eow_cfg_type          cfg,
   input  logic                          fire,
   input  logic                          cmd,
   input  logic [eow_pkg::NOW_W-1:0]     now_ms,
   output eow_pkg::eow_rsp_type          rsp
);
   import eow_pkg::*;

   localparam int NOW_BITS = (TIME_BITS < NOW_W) ? TIME_BITS : NOW_W;

   // Add an interval to a time, clamping at all ones
   function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0]     a,
                                                    input logic [INTERVAL_BITS-1:0] b);
      logic [TIME_BITS:0] sum;
      sum = {1'b0, a} + (TIME_BITS+1)'(b);
      return sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
   endfunction

   logic                     active_ff, active_in;
   logic [TIME_BITS-1:0]     start_ff, start_in;
   logic [TIME_BITS-1:0]     soft_dl_ff, soft_dl_in;
   logic [TIME_BITS-1:0]     reboot_dl_ff, reboot_dl_in;
   logic [INTERVAL_BITS-1:0] soft_int_ff, soft_int_in;
   logic [SEC_BITS-1:0]      backoff_ff, backoff_in;

   logic [TIME_BITS-1:0]     now_t;
   logic [SEC_BITS-1:0]      bo_clean;
   logic [INTERVAL_BITS:0]   soft_dbl;
   logic [INTERVAL_BITS-1:0] soft_cap;
   logic [INTERVAL_BITS-1:0] soft_next;
   logic [INTERVAL_BITS-1:0] soft_first_ms;
   logic [SEC_BITS:0]        bo_dbl;
   logic [SEC_BITS-1:0]      bo_next;
   logic                     soft_hit;
   logic                     reboot_hit;
   logic                     soft_fire;
   logic                     reboot_fire;
   logic [TIME_BITS-1:0]     offline;

   assign now_t = TIME_BITS'(now_ms[NOW_BITS-1:0]);

   // Pull an out-of-range backoff back to base
   assign bo_clean = (backoff_ff < cfg.reboot_floor_sec || backoff_ff > cfg.reboot_cap_sec)
                   ? cfg.reboot_floor_sec : backoff_ff;

   // Doubled soft interval, capped
   assign soft_first_ms = INTERVAL_BITS'(sec_to_ms(cfg.soft_base_s));
   assign soft_cap      = INTERVAL_BITS'(sec_to_ms(cfg.soft_max_s));
   assign soft_dbl      = {soft_int_ff, 1'b0};
   assign soft_next     = (soft_dbl < (INTERVAL_BITS+1)'(soft_cap))
                        ? soft_dbl[INTERVAL_BITS-1:0] : soft_cap;

   // Doubled reboot backoff, capped
   assign bo_dbl  = {bo_clean, 1'b0};
   assign bo_next = (bo_dbl < (SEC_BITS+1)'(cfg.reboot_cap_sec))
                  ? bo_dbl[SEC_BITS-1:0] : cfg.reboot_cap_sec;

   assign soft_hit   = now_t >= soft_dl_ff;
   assign reboot_hit = now_t >= reboot_dl_ff;

   // Next state for one event
   always_comb begin
      active_in    = active_ff;
      start_in     = start_ff;
      soft_dl_in   = soft_dl_ff;
      reboot_dl_in = reboot_dl_ff;
      soft_int_in  = soft_int_ff;
      backoff_in   = bo_clean;
      soft_fire    = 1'b0;
      reboot_fire  = 1'b0;
      if (!cmd) begin
         // connectivity back: drop the outage, return backoff to base
         active_in    = 1'b0;
         start_in     = '0;
         soft_dl_in   = '0;
         reboot_dl_in = '0;
         soft_int_in  = soft_first_ms;
         backoff_in   = cfg.reboot_floor_sec;
      end else if (!active_ff) begin
         // first failure: arm both deadlines
         active_in    = 1'b1;
         start_in     = now_t;
         soft_int_in  = soft_first_ms;
         soft_dl_in   = sat_add(now_t, soft_first_ms);
         reboot_dl_in = sat_add(now_t, INTERVAL_BITS'(sec_to_ms(bo_clean)));
      end else begin
         if (soft_hit) begin
            soft_fire   = 1'b1;
            soft_int_in = soft_next;
            soft_dl_in  = sat_add(now_t, soft_next);
         end
         if (reboot_hit) begin
            reboot_fire = 1'b1;
            backoff_in  = bo_next;
            if (cfg.dry_run) begin
               reboot_dl_in = sat_add(now_t, INTERVAL_BITS'(sec_to_ms(bo_next)));
            end else begin
               active_in    = 1'b0;
               start_in     = '0;
               soft_dl_in   = '0;
               reboot_dl_in = '0;
               soft_int_in  = soft_first_ms;
            end
         end
      end
   end

   // Time offline after this event
   assign offline = (active_in && now_t >= start_in) ? (now_t - start_in) : '0;

   always_comb begin
      rsp.soft_reset = soft_fire;
      rsp.reboot     = reboot_fire;
      rsp.in_outage  = active_in;
      rsp.down_ms    = NOW_W'(offline[NOW_BITS-1:0]);
      rsp.backoff_s  = backoff_in;
   end

   // Commit state when an event is processed
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         start_ff     <= '0;
         soft_dl_ff   <= '0;
         reboot_dl_ff <= '0;
         soft_int_ff  <= SOFT_INTERVAL_RST;
         backoff_ff   <= REBOOT_BASE_RST;
      end else if (fire) begin
         active_ff    <= active_in;
         start_ff     <= start_in;
         soft_dl_ff   <= soft_dl_in;
         reboot_dl_ff <= reboot_dl_in;
         soft_int_ff  <= soft_int_in;
         backoff_ff   <= backoff_in;
      end
   end

endmodule

// ===== rtl/core/escalating_outage_watchdog_top.sv =====
// ----------------------------------------------------------------------------
// escalating_outage_watchdog_top
// Connectivity watchdog with escalating soft reset and reboot backoff.
// Path: a request passes through the input register, then the event update
//   into the response register.
// Throughput: one request per cycle unless a held response stalls the pipe.
// Reset: synchronous; clears outage state, loads register defaults.
// ----------------------------------------------------------------------------
module escalating_outage_watchdog_top #(
   parameter int TIME_BITS = eow_pkg::TIME_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_we,
   input  logic [eow_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [eow_pkg::SEC_BITS-1:0]      csr_wdata,
   // request
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_cmd,
   input  logic [eow_pkg::NOW_W-1:0]         req_now_ms,
   // response
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_soft_reset,
   output logic                              rsp_reboot,
   output logic                              rsp_in_outage,
   output logic [eow_pkg::NOW_W-1:0]         rsp_offline_ms,
   output logic [eow_pkg::SEC_BITS-1:0]      rsp_backoff_s
);
   import eow_pkg::*;

   eow_cfg_type cfg;
   eow_rsp_type step_rsp;

   logic             in_valid_ff, in_valid_in;
   logic             in_cmd_ff;
   logic [NOW_W-1:0] in_now_ff;
   logic             out_valid_ff, out_valid_in;
   eow_rsp_type      out_ff;
   logic             stall;
   logic             advance;
   logic             accept;

   eow_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   eow_step #(
      .TIME_BITS (TIME_BITS)
   ) u_step (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .fire   (advance),
      .cmd    (in_cmd_ff),
      .now_ms (in_now_ff),
      .rsp    (step_rsp)
   );

   // Hold the pipe while a response waits
   assign stall     = out_valid_ff && !rsp_ready;
   assign advance   = in_valid_ff && !stall;
   assign req_ready = !in_valid_ff || !stall;
   assign accept    = req_valid && req_ready;

   assign in_valid_in  = accept || (in_valid_ff && stall);
   assign out_valid_in = advance || stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (accept) begin
         in_cmd_ff <= req_cmd;
         in_now_ff <= req_now_ms;
      end
   end

   // Capture the response
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= step_rsp;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_soft_reset = out_ff.soft_reset;
   assign rsp_reboot     = out_ff.reboot;
   assign rsp_in_outage  = out_ff.in_outage;
   assign rsp_offline_ms = out_ff.down_ms;
   assign rsp_backoff_s  = out_ff.backoff_s;

endmodule
